// ----- rtl/core/ntpc_pkg.sv -----
// Package for the nearest-target pursuit controller: types, constants, arctangent table.
// No dependencies.
package ntpc_pkg;

  localparam int unsigned IdBitsDefault = 8;
  localparam int unsigned CordicStepsDefault = 14;
  localparam int unsigned AtanTableLen = 20;

  localparam logic [1:0] FUNC_POSE = 2'd0;
  localparam logic [1:0] FUNC_CAND = 2'd1;
  localparam logic [1:0] FUNC_TICK = 2'd2;

  localparam logic [1:0] REG_SELECT = 2'd0;
  localparam logic [1:0] REG_KPLIN = 2'd1;
  localparam logic [1:0] REG_KPANG = 2'd2;
  localparam logic [1:0] REG_RADIUS = 2'd3;

  localparam logic signed [16:0] PiQ12 = 17'sd12868;
  localparam logic signed [16:0] TwoPiQ12 = 17'sd25736;
  localparam logic signed [35:0] HalfPiQ28 = 36'sd421657428;

  // Command handed from the front part to the back part.
  typedef struct packed {
    logic [15:0] tx;
    logic [15:0] ty;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [14:0] hd;
    logic [15:0] tid;
  } tick_cmd_t;

  function automatic logic signed [35:0] atan_q28(input logic [4:0] idx);
    logic signed [35:0] v;
    v = '0;
    case (idx)
      5'd0: v = 36'sd210828714;
      5'd1: v = 36'sd124459457;
      5'd2: v = 36'sd65760959;
      5'd3: v = 36'sd33381290;
      5'd4: v = 36'sd16755422;
      5'd5: v = 36'sd8385879;
      5'd6: v = 36'sd4193963;
      5'd7: v = 36'sd2097109;
      5'd8: v = 36'sd1048571;
      5'd9: v = 36'sd524287;
      5'd10: v = 36'sd262144;
      5'd11: v = 36'sd131072;
      5'd12: v = 36'sd65536;
      5'd13: v = 36'sd32768;
      5'd14: v = 36'sd16384;
      5'd15: v = 36'sd8192;
      5'd16: v = 36'sd4096;
      5'd17: v = 36'sd2048;
      5'd18: v = 36'sd1024;
      5'd19: v = 36'sd512;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/ntpc_front.sv -----
// Front part: keeps pose and target-list state, turns ticks into commands.
// Depends on ntpc_pkg.
module ntpc_front #(
  parameter int unsigned IdBits = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [1:0]             func_i,
  input  logic signed [15:0]     x_pos_i,
  input  logic signed [15:0]     y_pos_i,
  input  logic signed [14:0]     heading_i,
  input  logic [IdBits-1:0]      cand_id_i,
  input  logic                   cand_first_i,
  input  logic                   cand_last_i,
  input  logic                   select_nearest_i,
  input  logic                   release_i,
  input  logic                   caught_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output ntpc_pkg::tick_cmd_t    cmd_o
);
  import ntpc_pkg::*;

  // A candidate is worked in steps: difference, square, then sum and compare. Ticks
  // wait until the back part has reported whether the target was released.
  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SQ = 2'd1;
  localparam logic [1:0] F_CMP = 2'd2;
  localparam logic [1:0] F_WAIT = 2'd3;

  logic [1:0] st_q, st_d;
  logic signed [15:0] rx_q, ry_q, tx_q, ty_q, bx_q, by_q, cx_q, cy_q;
  logic signed [14:0] hd_q;
  logic [IdBits-1:0] tid_q, bid_q, cid_q;
  logic [32:0] bd_q;
  logic pose_q, held_q, cfirst_q, clast_q;
  logic signed [16:0] ddx_q, ddy_q;
  logic [33:0] sqx_q, sqy_q;
  logic [32:0] d2;
  logic [15:0] tid_ext;
  logic take;

  assign ready_o = (st_q == F_IDLE) && !(cmd_valid_o && !cmd_ready_i);
  assign d2 = sqx_q[32:0] + sqy_q[32:0];
  assign take = cfirst_q || (select_nearest_i && (d2 < bd_q));
  always_comb begin
    tid_ext = '0;
    tid_ext[IdBits-1:0] = tid_q;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      F_IDLE: begin
        if (valid_i && ready_o && func_i == FUNC_CAND) begin
          st_d = F_SQ;
        end else if (valid_i && ready_o && func_i == FUNC_TICK && pose_q && held_q) begin
          st_d = F_WAIT;
        end
      end
      F_SQ: st_d = F_CMP;
      F_CMP: st_d = F_IDLE;
      F_WAIT: begin
        if (release_i) begin
          st_d = F_IDLE;
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
      pose_q <= 1'b0;
      held_q <= 1'b0;
      cmd_valid_o <= 1'b0;
      rx_q <= '0; ry_q <= '0; hd_q <= '0;
      tx_q <= '0; ty_q <= '0; tid_q <= '0;
      bx_q <= '0; by_q <= '0; bid_q <= '0; bd_q <= '0;
    end else begin
      st_q <= st_d;
      if (cmd_valid_o && cmd_ready_i) begin
        cmd_valid_o <= 1'b0;
      end
      if (st_q == F_IDLE && valid_i && ready_o) begin
        if (func_i == FUNC_POSE) begin
          rx_q <= x_pos_i; ry_q <= y_pos_i; hd_q <= heading_i; pose_q <= 1'b1;
        end else if (func_i == FUNC_TICK && pose_q && held_q) begin
          cmd_valid_o <= 1'b1;
        end
      end
      if (st_q == F_WAIT && release_i && caught_i) begin
        held_q <= 1'b0;
      end
      if (st_q == F_CMP) begin
        if (take) begin
          bx_q <= cx_q; by_q <= cy_q; bid_q <= cid_q; bd_q <= d2;
        end
        if (clast_q) begin
          tx_q <= take ? cx_q : bx_q;
          ty_q <= take ? cy_q : by_q;
          tid_q <= take ? cid_q : bid_q;
          held_q <= 1'b1;
        end
      end
    end
  end

  // release_i pulses for one cycle when the back part finishes a tick;
  // caught_i comes with it when the target was reached and must be dropped.
  always_ff @(posedge clk_i) begin
    if (st_q == F_IDLE && valid_i && ready_o) begin
      cx_q <= x_pos_i; cy_q <= y_pos_i; cid_q <= cand_id_i;
      cfirst_q <= cand_first_i; clast_q <= cand_last_i;
      ddx_q <= 17'(x_pos_i) - 17'(rx_q);
      ddy_q <= 17'(y_pos_i) - 17'(ry_q);
    end
    if (st_q == F_SQ) begin
      sqx_q <= 34'(ddx_q * ddx_q);
      sqy_q <= 34'(ddy_q * ddy_q);
    end
  end

  assign cmd_o = '{tx: tx_q, ty: ty_q, rx: rx_q, ry: ry_q, hd: hd_q, tid: tid_ext};

  a_cmd_needs_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> st_q == F_WAIT)
    else $error("command pending outside wait state");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == F_WAIT |-> !ready_o)
    else $error("front accepted while tick in flight");
  a_sq_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == F_SQ |=> st_q == F_CMP)
    else $error("candidate sequence broken");
endmodule

// ----- rtl/core/ntpc_back.sv -----
// Back part: distance by bitwise square root, angle by iterative CORDIC, gains and saturation.
// Depends on ntpc_pkg.
module ntpc_back #(
  parameter int unsigned IdBits = 8,
  parameter int unsigned CordicSteps = 14
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  ntpc_pkg::tick_cmd_t  cmd_i,
  input  logic [11:0]          kp_linear_i,
  input  logic [11:0]          kp_angular_i,
  input  logic [14:0]          capture_radius_i,
  output logic                 done_o,
  output logic                 caught_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [14:0]          linear_speed_o,
  output logic signed [15:0]   angular_speed_o,
  output logic                 caught_flag_o,
  output logic [IdBits-1:0]    caught_id_o
);
  import ntpc_pkg::*;

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_DIFF = 3'd1;
  localparam logic [2:0] B_SQ = 3'd2;
  localparam logic [2:0] B_CHK = 3'd3;
  localparam logic [2:0] B_ITER = 3'd4;
  localparam logic [2:0] B_MUL = 3'd5;
  localparam logic [2:0] B_OUT = 3'd6;
  localparam int unsigned CntW = 5;

  logic [2:0] st_q;
  logic signed [16:0] dx_q, dy_q;
  logic [33:0] sqx_q, sqy_q;
  logic [29:0] r2_q;
  logic [32:0] rem_q;
  logic [32:0] root_q;
  logic [32:0] bit_q;
  logic signed [35:0] cx_q, cy_q, cz_q;
  logic [CntW-1:0] i_q;
  logic [28:0] lin_q;
  logic signed [30:0] ang_q;
  logic [IdBits-1:0] tid_q;
  logic [32:0] d2;
  logic signed [35:0] xs, ys, zround;
  logic signed [16:0] ang12, err, errw;
  logic [33:0] trial;
  logic sqrt_busy;

  assign d2 = sqx_q[32:0] + sqy_q[32:0];
  assign xs = cx_q >>> i_q;
  assign ys = cy_q >>> i_q;
  assign zround = (cz_q + 36'sd32768) >>> 16;
  assign ang12 = zround[16:0];
  assign err = ang12 - 17'(signed'(cmd_i.hd));
  assign errw = (err > PiQ12) ? err - TwoPiQ12 : ((err < -PiQ12) ? err + TwoPiQ12 : err);
  assign trial = 34'(root_q) + 34'(bit_q);
  assign sqrt_busy = bit_q != '0;
  assign cmd_ready_o = st_q == B_IDLE && !out_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_IDLE;
      out_valid_o <= 1'b0;
      done_o <= 1'b0;
      caught_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      caught_o <= 1'b0;
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (st_q)
        B_IDLE: if (cmd_valid_i && cmd_ready_o) st_q <= B_DIFF;
        B_DIFF: st_q <= B_SQ;
        B_SQ: st_q <= B_CHK;
        B_CHK: begin
          if ({1'b0, d2} <= 34'(r2_q)) begin
            out_valid_o <= 1'b1; done_o <= 1'b1; caught_o <= 1'b1;
            st_q <= B_IDLE;
          end else begin
            st_q <= B_ITER;
          end
        end
        B_ITER: if (i_q == CntW'(CordicSteps) && !sqrt_busy) st_q <= B_MUL;
        B_MUL: st_q <= B_OUT;
        B_OUT: begin
          out_valid_o <= 1'b1; done_o <= 1'b1; st_q <= B_IDLE;
        end
        default: st_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      B_IDLE: begin
        dx_q <= 17'(signed'(cmd_i.tx)) - 17'(signed'(cmd_i.rx));
        dy_q <= 17'(signed'(cmd_i.ty)) - 17'(signed'(cmd_i.ry));
        tid_q <= cmd_i.tid[IdBits-1:0];
      end
      B_DIFF: begin
        sqx_q <= 34'(dx_q * dx_q);
        sqy_q <= 34'(dy_q * dy_q);
        r2_q <= 30'(capture_radius_i * capture_radius_i);
      end
      B_SQ: ;
      B_CHK: begin
        linear_speed_o <= '0; angular_speed_o <= '0;
        caught_flag_o <= 1'b1; caught_id_o <= tid_q;
        // The squared distance is below 2^33, so the root starts at 4^16.
        rem_q <= d2; root_q <= '0; bit_q <= 33'(1) << 32;
        i_q <= '0;
        if (dx_q < 0) begin
          if (dy_q >= 0) begin
            cx_q <= 36'(dy_q) <<< 14; cy_q <= -(36'(dx_q) <<< 14); cz_q <= HalfPiQ28;
          end else begin
            cx_q <= -(36'(dy_q) <<< 14); cy_q <= 36'(dx_q) <<< 14; cz_q <= -HalfPiQ28;
          end
        end else begin
          cx_q <= 36'(dx_q) <<< 14; cy_q <= 36'(dy_q) <<< 14; cz_q <= '0;
        end
      end
      B_ITER: begin
        if (sqrt_busy) begin
          if ({1'b0, rem_q} >= trial) begin
            rem_q <= rem_q - trial[32:0];
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
        if (i_q != CntW'(CordicSteps)) begin
          if (cy_q > 0) begin
            cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + atan_q28(i_q);
          end else begin
            cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - atan_q28(i_q);
          end
          i_q <= i_q + 1'b1;
        end
      end
      B_MUL: begin
        lin_q <= 29'(kp_linear_i * 29'(root_q[16:0]));
        ang_q <= 31'($signed({1'b0, kp_angular_i}) * errw);
      end
      B_OUT: begin
        linear_speed_o <= (lin_q[28:10] > 19'd32767) ? 15'h7FFF : lin_q[24:10];
        if ((ang_q >>> 12) > 31'sd32767) angular_speed_o <= 16'sh7FFF;
        else if ((ang_q >>> 12) < -31'sd32768) angular_speed_o <= -16'sh8000;
        else angular_speed_o <= 16'(ang_q >>> 12);
        caught_flag_o <= 1'b0; caught_id_o <= '0;
      end
      default: ;
    endcase
  end

  a_done_with_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> out_valid_o)
    else $error("done without a result");
  a_caught_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    caught_o |-> done_o && caught_flag_o)
    else $error("release without a caught result");
  a_idle_only_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_o) |=> st_q == B_DIFF)
    else $error("command lost");
endmodule

// ----- rtl/core/nearest_target_pursuit_controller_core.sv -----
// Top level of the nearest-target pursuit controller: APB registers, front and back parts.
// Depends on ntpc_pkg, ntpc_front and ntpc_back.
//
// Pose items and target candidates are absorbed by the front part; a candidate
// occupies it through its difference, square and compare steps, a pose item only as it is taken.
// A control tick with a pose seen and a target held is handed to the back part,
// which squares the offset, checks the capture radius, then runs the bitwise
// square root (17 steps for the 33-bit squared distance) and a CORDIC_STEPS-step
// CORDIC side by side, one step a cycle, followed by the gain multiply and
// saturation; a caught tick ends at the radius check. The front part holds further
// items until the tick is done, since its outcome may release the target.
// A finished beat waits in the output register; the next items are taken
// meanwhile, and a new tick waits only for that register to be read.
module nearest_target_pursuit_controller_core #(
  parameter int unsigned ID_BITS = ntpc_pkg::IdBitsDefault,
  parameter int unsigned CORDIC_STEPS = ntpc_pkg::CordicStepsDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [1:0]            func_i,
  input  logic signed [15:0]    x_pos_i,
  input  logic signed [15:0]    y_pos_i,
  input  logic signed [14:0]    heading_i,
  input  logic [ID_BITS-1:0]    cand_id_i,
  input  logic                  cand_first_i,
  input  logic                  cand_last_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [14:0]           linear_speed_o,
  output logic signed [15:0]    angular_speed_o,
  output logic                  caught_o,
  output logic [ID_BITS-1:0]    caught_id_o
);
  import ntpc_pkg::*;

  logic sel_q;
  logic [11:0] kpl_q, kpa_q;
  logic [14:0] rad_q;
  logic cmd_valid, cmd_ready, done, rel;
  tick_cmd_t cmd;
  logic [1:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b1; kpl_q <= 12'd512; kpa_q <= 12'd1280; rad_q <= 15'd512;
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        REG_SELECT: sel_q <= pwdata[0];
        REG_KPLIN: kpl_q <= pwdata[11:0];
        REG_KPANG: kpa_q <= pwdata[11:0];
        REG_RADIUS: rad_q <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (ridx)
      REG_SELECT: prdata = {31'd0, sel_q};
      REG_KPLIN: prdata = {20'd0, kpl_q};
      REG_KPANG: prdata = {20'd0, kpa_q};
      REG_RADIUS: prdata = {17'd0, rad_q};
      default: prdata = '0;
    endcase
  end

  // The front part leaves its wait state on done; the target drops on caught.
  ntpc_front #(.IdBits(ID_BITS)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .func_i, .x_pos_i, .y_pos_i,
    .heading_i, .cand_id_i, .cand_first_i, .cand_last_i,
    .select_nearest_i(sel_q), .release_i(done),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd),
    .caught_i(rel)
  );

  ntpc_back #(.IdBits(ID_BITS), .CordicSteps(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .kp_linear_i(kpl_q), .kp_angular_i(kpa_q),
    .capture_radius_i(rad_q), .done_o(done), .caught_o(rel),
    .out_valid_o(valid_o), .out_ready_i(ready_i),
    .linear_speed_o, .angular_speed_o, .caught_flag_o(caught_o), .caught_id_o
  );

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(linear_speed_o))
    else $error("result beat changed while stalled");
  a_caught_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && caught_o |-> linear_speed_o == '0)
    else $error("caught beat with nonzero speed");
  a_no_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel |-> done)
    else $error("release without completion");
endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for the nearest-target pursuit controller core.
// Depends on ntpc_pkg and nearest_target_pursuit_controller_core.
module tb_top;
  import ntpc_pkg::*;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [14:0] hd;
    logic [7:0]         id;
    logic               first;
    logic               last;
  } beat_t;

  typedef struct packed {
    logic [14:0]        lin;
    logic signed [15:0] ang;
    logic               caught;
    logic [7:0]         cid;
  } cmd_t;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // Arctangent of 2^-i in Q.28, used by the vectoring predictor.
  localparam longint ATAN_Q28 [20] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
    2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic valid_i = 1'b0;
  logic ready_o;
  logic [1:0] func_i = '0;
  logic signed [15:0] x_pos_i = '0, y_pos_i = '0;
  logic signed [14:0] heading_i = '0;
  logic [7:0] cand_id_i = '0;
  logic cand_first_i = 1'b0, cand_last_i = 1'b0;
  logic valid_o;
  logic ready_i = 1'b0;
  logic [14:0] linear_speed_o;
  logic signed [15:0] angular_speed_o;
  logic caught_o;
  logic [7:0] caught_id_o;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  nearest_target_pursuit_controller_core uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .valid_i, .ready_o, .func_i, .x_pos_i, .y_pos_i, .heading_i, .cand_id_i,
    .cand_first_i, .cand_last_i, .valid_o, .ready_i, .linear_speed_o,
    .angular_speed_o, .caught_o, .caught_id_o
  );

  beat_t beat_q[$];
  cmd_t  cmd_q[$];
  int    errors = 0;
  int    cmds_seen = 0;
  int    catches_seen = 0;
  bit    no_idle = 1'b0;

  // Predictor copy of the register file and of the controller state.
  longint sel_nearest = 1, gain_lin = 512, gain_ang = 1280, cap_radius = 512;
  longint rob_x = 0, rob_y = 0, rob_hd = 0;
  longint tgt_x = 0, tgt_y = 0, best_x = 0, best_y = 0, best_d2 = 0;
  logic [7:0] tgt_id = '0, best_id = '0;
  bit pose_ok = 1'b0, tgt_ok = 1'b0;

  function automatic longint int_sqrt(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) << 40;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Bearing of (dx, dy) in Q3.12 by fixed-length CORDIC vectoring.
  function automatic longint bearing_q12(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    x = dx * 16384;
    y = dy * 16384;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HalfPiQ28;
      end else begin
        x = -y; y = t; z = -HalfPiQ28;
      end
    end
    for (int i = 0; i < CordicStepsDefault; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_Q28[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_Q28[i];
      end
    end
    return (z + 32768) >>> 16;
  endfunction

  // Applies one accepted beat to the predicted state and queues any command.
  function automatic void absorb_beat(beat_t b);
    longint dx, dy, d2, lin, err, ang;
    cmd_t c;
    case (b.func)
      FUNC_POSE: begin
        rob_x = b.x; rob_y = b.y; rob_hd = b.hd;
        pose_ok = 1'b1;
      end
      FUNC_CAND: begin
        dx = longint'(b.x) - rob_x;
        dy = longint'(b.y) - rob_y;
        d2 = dx * dx + dy * dy;
        if (b.first || (sel_nearest != 0 && d2 < best_d2)) begin
          best_x = b.x; best_y = b.y; best_id = b.id; best_d2 = d2;
        end
        if (b.last) begin
          tgt_x = best_x; tgt_y = best_y; tgt_id = best_id;
          tgt_ok = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (pose_ok && tgt_ok) begin
          dx = tgt_x - rob_x;
          dy = tgt_y - rob_y;
          d2 = dx * dx + dy * dy;
          c = '0;
          if (d2 <= cap_radius * cap_radius) begin
            c.caught = 1'b1;
            c.cid = tgt_id;
            tgt_ok = 1'b0;
          end else begin
            lin = (gain_lin * int_sqrt(d2)) >> 10;
            if (lin > 32767) lin = 32767;
            err = bearing_q12(dx, dy) - rob_hd;
            if (err > PiQ12) err = err - TwoPiQ12;
            else if (err < -PiQ12) err = err + TwoPiQ12;
            ang = (gain_ang * err) >>> 12;
            if (ang > 32767) ang = 32767;
            if (ang < -32768) ang = -32768;
            c.lin = lin[14:0];
            c.ang = ang[15:0];
          end
          cmd_q = {cmd_q, c};
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  // Sender: presents queued beats, holding each until it is taken.
  beat_t cur_beat;
  int    send_gap = 0;
  int    beats_sent = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_i <= 1'b0;
      send_gap <= 0;
    end else begin
      if (valid_i && ready_o) begin
        absorb_beat(cur_beat);
        beats_sent <= beats_sent + 1;
      end
      if (!(valid_i && !ready_o)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          valid_i <= 1'b0;
        end else if (beat_q.size() != 0) begin
          cur_beat = beat_q.pop_front();
          func_i <= cur_beat.func;
          x_pos_i <= cur_beat.x;
          y_pos_i <= cur_beat.y;
          heading_i <= cur_beat.hd;
          cand_id_i <= cur_beat.id;
          cand_first_i <= cur_beat.first;
          cand_last_i <= cur_beat.last;
          valid_i <= 1'b1;
          send_gap <= draw_wait();
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here and requested by toggling hold_go.
  bit hold_go = 1'b0, hold_seen = 1'b0;
  int hold_cnt = 0;

  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go != hold_seen) begin
      hold_cnt <= 300;
      hold_seen <= hold_go;
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on command %0d: %s got %0d expected %0d", cmds_seen, what, got, want);
    errors++;
  endtask

  // Receiver: random stalls, then checks each command beat against the oldest prediction.
  int  recv_stall = 0;
  bit  next_ready;
  cmd_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_i <= 1'b0;
      recv_stall <= 0;
    end else begin
      if (valid_o && ready_i) begin
        if (cmd_q.size() == 0) begin
          report_mismatch("unexpected command beat", 1, 0);
        end else begin
          want = cmd_q.pop_front();
          if (linear_speed_o !== want.lin)
            report_mismatch("linear_speed", linear_speed_o, want.lin);
          if (angular_speed_o !== want.ang)
            report_mismatch("angular_speed", angular_speed_o, want.ang);
          if (caught_o !== want.caught)
            report_mismatch("caught", caught_o, want.caught);
          if (caught_id_o !== want.cid)
            report_mismatch("caught_id", caught_id_o, want.cid);
          if (want.caught) catches_seen++;
        end
        cmds_seen++;
        recv_stall <= draw_wait();
        next_ready = 1'b0;
      end else if (hold_cnt != 0) begin
        next_ready = 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      ready_i <= next_ready;
    end
  end

  // Register writes: setup cycle then access cycle.
  task automatic write_reg(logic [1:0] idx, longint value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value[31:0];
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SELECT: sel_nearest = value & 1;
      REG_KPLIN:  gain_lin = value & 12'hFFF;
      REG_KPANG:  gain_ang = value & 12'hFFF;
      default:    cap_radius = value & 15'h7FFF;
    endcase
  endtask

  task automatic push_beat(logic [1:0] f, int x, int y, int hd, int id, bit fst, bit lst);
    beat_t b;
    b.func = f; b.x = x[15:0]; b.y = y[15:0]; b.hd = hd[14:0];
    b.id = id[7:0]; b.first = fst; b.last = lst;
    beat_q = {beat_q, b};
  endtask

  // Waits until every beat is taken and every command has come, then lets the
  // back part settle before anything touches the registers.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (beat_q.size() != 0 || valid_i || cmd_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic int rand_hd();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 32767) - 16384;
    return $urandom_range(0, 25736) - 12868;
  endfunction

  // One random burst: mostly pose / candidate list / ticks, sometimes noise.
  task automatic push_random(int n_beats);
    int px, py, len, k, spread;
    px = 0; py = 0;
    k = 0;
    while (k < n_beats) begin
      if ($urandom_range(0, 7) == 0) begin
        // Stray beats: unused func, orphan candidate, tick, or an unopened list.
        push_beat(2'($urandom_range(0, 3)), $urandom, $urandom, rand_hd(), $urandom,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        k++;
      end else begin
        spread = ($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(16, 4096);
        if ($urandom_range(0, 3) != 0) begin
          px = $urandom; py = $urandom;
          px = px - (px & 32'h10000) * 2;
          push_beat(FUNC_POSE, px, py, rand_hd(), $urandom, 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
          k++;
        end
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++) begin
          push_beat(FUNC_CAND, px + $urandom_range(0, spread) - spread / 2,
                    py + $urandom_range(0, spread) - spread / 2, $urandom, $urandom,
                    i == 0, i == len - 1);
          if (i == 1 && $urandom_range(0, 5) == 0)
            push_beat(FUNC_POSE, px + 64, py - 64, rand_hd(), 0, 0, 0);
        end
        k += len;
        for (int t = $urandom_range(1, 4); t > 0; t--) begin
          push_beat(FUNC_TICK, $urandom, $urandom, $urandom, $urandom,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          k++;
        end
      end
    end
  endtask

  // Register settings per random phase, extremes included.
  longint phase_cfg [5][4] = '{
    '{1, 512, 1280, 512},
    '{0, 4095, 4095, 0},
    '{1, 0, 0, 32767},
    '{1, 4095, 4095, 2048},
    '{0, 300, 2000, 100}
  };

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset settings.
    push_beat(FUNC_TICK, 0, 0, 0, 0, 0, 0);                 // nothing held: silent
    push_beat(FUNC_POSE, 0, 0, 0, 0, 0, 0);
    push_beat(FUNC_TICK, 0, 0, 0, 0, 0, 0);                 // pose but no target
    push_beat(FUNC_NONE, -1, -1, -1, 255, 1, 1);            // unused func is dropped
    push_beat(FUNC_CAND, 5000, 0, 0, 7, 0, 1);              // orphan vs. reset best
    push_beat(FUNC_TICK, 0, 0, 0, 0, 0, 0);
    push_beat(FUNC_CAND, 3000, 3000, 0, 1, 1, 0);           // nearest with a tie
    push_beat(FUNC_CAND, -3000, 3000, 0, 2, 0, 0);
    push_beat(FUNC_CAND, 1000, -2000, 0, 3, 0, 1);
    push_beat(FUNC_TICK, 0, 0, 0, 0, 0, 0);
    push_beat(FUNC_POSE, -32768, 32767, 12868, 0, 0, 0);
    push_beat(FUNC_CAND, 32767, -32768, 0, 255, 1, 1);      // farthest corner
    push_beat(FUNC_TICK, 0, 0, 0, 0, 0, 0);
    push_beat(FUNC_POSE, 32767, -32768, -12868, 0, 0, 0);
    push_beat(FUNC_TICK, 0, 0, 0, 0, 0, 0);                 // right on the target
    push_beat(FUNC_TICK, 0, 0, 0, 0, 0, 0);                 // target already dropped
    push_beat(FUNC_POSE, 100, 100, 16383, 0, 0, 0);         // heading out of range
    push_beat(FUNC_CAND, -20000, 100, 0, 9, 1, 1);
    push_beat(FUNC_TICK, 0, 0, 0, 0, 0, 0);
    push_beat(FUNC_POSE, 100, 100, -16384, 0, 0, 0);
    push_beat(FUNC_TICK, 0, 0, 0, 0, 0, 0);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      for (int r = 0; r < 4; r++) write_reg(r[1:0], phase_cfg[ph][r]);
      no_idle = (ph == 3);
      if (ph == 2) hold_go = ~hold_go;
      push_random(210);
      wait_idle();
    end

    $display("ran %0d input beats over five register settings plus a directed set;",
             beats_sent);
    $display("checked %0d command beats, %0d of them target captures", cmds_seen,
             catches_seen);
    if (errors == 0 && cmd_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("run did not finish in time");
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/ntpc_pkg.sv
rtl/core/ntpc_front.sv
rtl/core/ntpc_back.sv
rtl/core/nearest_target_pursuit_controller_core.sv
sim/tb_top.sv
